/* design/color_bin_compaction_unit_defines.svh */
// Assertion macros shared by the color bin compaction checker.
// No dependencies; included by the checker file.
`ifndef COLOR_BIN_COMPACTION_UNIT_DEFINES_SVH
`define COLOR_BIN_COMPACTION_UNIT_DEFINES_SVH

// same-cycle implication
`define CBC_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("cbc assertion failed");

// next-cycle implication
`define CBC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("cbc assertion failed");

`endif

/* design/cbc_pkg.sv */
// Shared widths, constants and control structs of the color bin compaction unit.
// No dependencies.
package cbc_pkg;

   localparam int PIX_W   = 8;
   localparam int CSR_W   = 5;
   localparam int IDX_W   = 12;
   localparam int USED_W  = 13;
   localparam int EPOCH_W = 8;

   localparam logic [CSR_W-1:0] CSR_RESET = 5'd16;

   typedef struct packed {
      logic load_item;
      logic mul1;
      logic mul2;
      logic addr;
      logic lookup;
      logic emit;
      logic clr_write;
      logic clr_done;
   } cmd_type;

   typedef struct packed {
      logic wrap_needed;
      logic sweep_last;
      logic slot_free;
   } sts_type;

endpackage

/* design/cbc_req_if.sv */
// Pixel word channel: valid/ready plus the RGB payload and first-pixel flag.
// Depends on cbc_pkg.
interface cbc_req_if import cbc_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [PIX_W-1:0] blue;
   logic [PIX_W-1:0] green;
   logic [PIX_W-1:0] red;
   logic             first_pixel;

   modport source (output valid, blue, green, red, first_pixel, input ready);
   modport sink   (input valid, blue, green, red, first_pixel, output ready);
endinterface

/* design/cbc_rsp_if.sv */
// Result word channel: valid/ready plus dense bin index and used-bin count.
// Depends on cbc_pkg.
interface cbc_rsp_if import cbc_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [IDX_W-1:0]  bin_index;
   logic [USED_W-1:0] used_bins;

   modport source (output valid, bin_index, used_bins, input ready);
   modport sink   (input valid, bin_index, used_bins, output ready);
endinterface

/* design/cbc_ram.sv */
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module cbc_ram #(
   parameter int WIDTH = 20,
   parameter int DEPTH = 4096
) (
   input  logic                                      clock,
   input  logic                                      we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                          wdata,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                          rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;
endmodule

/* design/cbc_ctrl.sv */
// Sequencer of the color bin compaction unit: sweep, quantize, lookup, emit.
// Depends on cbc_pkg.
module cbc_ctrl import cbc_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  sts_type sts,
   output cmd_type cmd
);
   typedef enum logic [3:0] {
      S_CLEAR_INIT,
      S_IDLE,
      S_CLEAR_ITEM,
      S_MUL1,
      S_MUL2,
      S_ADDR,
      S_READ,
      S_LOOKUP,
      S_EMIT
   } state_type;

   state_type state_ff, state_in;
   logic      ready_ff;
   logic      accept;

   assign accept    = req_valid & ready_ff;
   assign req_ready = ready_ff;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_CLEAR_INIT: begin
            cmd.clr_write = 1'b1;
            if (sts.sweep_last) begin
               cmd.clr_done = 1'b1;
               state_in     = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               cmd.load_item = 1'b1;
               state_in      = sts.wrap_needed ? S_CLEAR_ITEM : S_MUL1;
            end
         end
         S_CLEAR_ITEM: begin
            cmd.clr_write = 1'b1;
            if (sts.sweep_last) begin
               cmd.clr_done = 1'b1;
               state_in     = S_MUL1;
            end
         end
         S_MUL1: begin
            cmd.mul1 = 1'b1;
            state_in = S_MUL2;
         end
         S_MUL2: begin
            cmd.mul2 = 1'b1;
            state_in = S_ADDR;
         end
         S_ADDR: begin
            cmd.addr = 1'b1;
            state_in = S_READ;
         end
         S_READ: begin
            state_in = S_LOOKUP;
         end
         S_LOOKUP: begin
            cmd.lookup = 1'b1;
            state_in   = S_EMIT;
         end
         S_EMIT: begin
            if (sts.slot_free) begin
               cmd.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_CLEAR_INIT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR_INIT;
         ready_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         ready_ff <= (state_in == S_IDLE);
      end
   end
endmodule

/* design/cbc_datapath.sv */
// Datapath: bin register, quantizer multiplies, epoch-tagged bin table, result word.
// Depends on cbc_pkg and cbc_ram.
module cbc_datapath import cbc_pkg::*; #(
   parameter int MAX_BINS_PER_CHANNEL = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  cmd_type           cmd,
   output sts_type           sts,
   input  logic [PIX_W-1:0]  req_blue,
   input  logic [PIX_W-1:0]  req_green,
   input  logic [PIX_W-1:0]  req_red,
   input  logic              req_first_pixel,
   input  logic              csr_we,
   input  logic [CSR_W-1:0]  csr_wdata,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [IDX_W-1:0]  rsp_bin_index,
   output logic [USED_W-1:0] rsp_used_bins
);
   localparam int MAXB   = MAX_BINS_PER_CHANNEL;
   localparam int NW     = $clog2(MAXB + 1);
   localparam int DEPTH  = MAXB * MAXB * MAXB;
   localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int WORD_W = EPOCH_W + IDX_W;
   localparam int PW     = PIX_W + NW;

   logic [CSR_W-1:0]   csr_ff;
   logic [NW-1:0]      n;
   logic [PIX_W-1:0]   b_ff, g_ff, r_ff;
   logic [PW-1:0]      prod_b, prod_g, prod_r;
   logic [NW-1:0]      qb_ff, qg_ff, qr_ff;
   logic [2*NW-1:0]    t_in, t_ff;
   logic [3*NW-1:0]    raw;
   logic [AW-1:0]      addr_ff;
   logic [AW-1:0]      sweep_ff;
   logic [EPOCH_W-1:0] epoch_ff;
   logic [USED_W-1:0]  next_ff, next_inc;
   logic [WORD_W-1:0]  rdata, wdata;
   logic [AW-1:0]      waddr;
   logic               we, hit;
   logic [IDX_W-1:0]   res_idx_ff, res_idx_in;
   logic [USED_W-1:0]  res_used_ff, res_used_in;
   logic               rsp_valid_ff;
   logic [IDX_W-1:0]   rsp_idx_ff;
   logic [USED_W-1:0]  rsp_used_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff <= CSR_RESET;
      end else if (csr_we) begin
         csr_ff <= csr_wdata;
      end
   end

   // zero acts as one bin, anything above the table limit is clamped
   always_comb begin
      if (csr_ff == '0) begin
         n = NW'(1);
      end else if ({1'b0, csr_ff} > 6'(MAXB)) begin
         n = NW'(MAXB);
      end else begin
         n = NW'(csr_ff);
      end
   end

   assign prod_b = PW'(b_ff) * PW'(n);
   assign prod_g = PW'(g_ff) * PW'(n);
   assign prod_r = PW'(r_ff) * PW'(n);
   assign t_in   = (2*NW)'(qg_ff) + (2*NW)'(n) * (2*NW)'(qr_ff);
   assign raw    = (3*NW)'(qb_ff) + (3*NW)'(n) * (3*NW)'(t_ff);

   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         b_ff <= req_blue;
         g_ff <= req_green;
         r_ff <= req_red;
      end
      if (cmd.mul1) begin
         qb_ff <= prod_b[PW-1:PIX_W];
         qg_ff <= prod_g[PW-1:PIX_W];
         qr_ff <= prod_r[PW-1:PIX_W];
      end
      if (cmd.mul2) begin
         t_ff <= t_in;
      end
      if (cmd.addr) begin
         addr_ff <= raw[AW-1:0];
      end
      if (cmd.lookup) begin
         res_idx_ff  <= res_idx_in;
         res_used_ff <= res_used_in;
      end
      if (cmd.emit) begin
         rsp_idx_ff  <= res_idx_ff;
         rsp_used_ff <= res_used_ff;
      end
   end

   // epoch zero marks a swept entry; live epochs run 1..max
   assign hit         = (rdata[WORD_W-1:IDX_W] == epoch_ff);
   assign next_inc    = next_ff + USED_W'(1);
   assign res_idx_in  = hit ? rdata[IDX_W-1:0] : next_ff[IDX_W-1:0];
   assign res_used_in = hit ? next_ff : next_inc;

   assign we    = cmd.clr_write | (cmd.lookup & ~hit);
   assign waddr = cmd.clr_write ? sweep_ff : addr_ff;
   assign wdata = cmd.clr_write ? '0 : {epoch_ff, next_ff[IDX_W-1:0]};

   cbc_ram #(
      .WIDTH (WORD_W),
      .DEPTH (DEPTH)
   ) u_table (
      .clock (clock),
      .we    (we),
      .waddr (waddr),
      .wdata (wdata),
      .raddr (addr_ff),
      .rdata (rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         sweep_ff     <= '0;
         epoch_ff     <= EPOCH_W'(1);
         next_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.clr_write) begin
            sweep_ff <= sts.sweep_last ? '0 : sweep_ff + AW'(1);
         end
         if (cmd.clr_done) begin
            epoch_ff <= EPOCH_W'(1);
         end else if (cmd.load_item && req_first_pixel && (epoch_ff != '1)) begin
            epoch_ff <= epoch_ff + EPOCH_W'(1);
         end
         if (cmd.load_item && req_first_pixel) begin
            next_ff <= '0;
         end else if (cmd.lookup && !hit) begin
            next_ff <= next_inc;
         end
         if (cmd.emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign sts.wrap_needed = req_first_pixel & (epoch_ff == '1);
   assign sts.sweep_last  = (sweep_ff == AW'(DEPTH - 1));
   assign sts.slot_free   = ~rsp_valid_ff | rsp_ready;

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_bin_index = rsp_idx_ff;
   assign rsp_used_bins = rsp_used_ff;
endmodule

/* design/color_bin_compaction_unit.sv */
// Color bin compaction unit: an accepted pixel word runs through MUL1, MUL2, ADDR, READ, LOOKUP
// and EMIT before its result word is valid; no new pixel word is taken until EMIT is done.
// A result word waits in the output register while the next pixel word is taken.
// Reset (synchronous) starts a sweep over all MAX_BINS_PER_CHANNEL^3 entries of the table;
// a first_pixel when the 8-bit epoch is exhausted (every 255 images) repeats that sweep.
// Depends on cbc_pkg, cbc_req_if, cbc_rsp_if, cbc_ctrl, cbc_datapath.
module color_bin_compaction_unit import cbc_pkg::*; #(
   parameter int MAX_BINS_PER_CHANNEL = 16
) (
   input  logic             clock,
   input  logic             reset,
   cbc_req_if.sink          req_ch,
   cbc_rsp_if.source        rsp_ch,
   input  logic             csr_we,
   input  logic [CSR_W-1:0] csr_wdata
);
   cmd_type cmd;
   sts_type sts;

   cbc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   cbc_datapath #(
      .MAX_BINS_PER_CHANNEL (MAX_BINS_PER_CHANNEL)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .req_blue        (req_ch.blue),
      .req_green       (req_ch.green),
      .req_red         (req_ch.red),
      .req_first_pixel (req_ch.first_pixel),
      .csr_we          (csr_we),
      .csr_wdata       (csr_wdata),
      .rsp_valid       (rsp_ch.valid),
      .rsp_ready       (rsp_ch.ready),
      .rsp_bin_index   (rsp_ch.bin_index),
      .rsp_used_bins   (rsp_ch.used_bins)
   );
endmodule

/* design/cbc_checker.sv */
// Port-level checker for the color bin compaction unit, bound to the top level.
// Depends on cbc_pkg and color_bin_compaction_unit_defines.svh.
`include "color_bin_compaction_unit_defines.svh"

module cbc_checker import cbc_pkg::*; (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic [IDX_W-1:0]  rsp_bin_index,
   input logic [USED_W-1:0] rsp_used_bins
);
   logic [1:0] pend_ff;
   logic       req_acc, rsp_acc;

   assign req_acc = req_valid & req_ready;
   assign rsp_acc = rsp_valid & rsp_ready;

   // words accepted but not yet delivered
   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
      end else begin
         pend_ff <= pend_ff + 2'(req_acc) - 2'(rsp_acc);
      end
   end

   `CBC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_bin_index) && $stable(rsp_used_bins))
   `CBC_ASSERT_IMPL(a_rsp_has_item, clock, reset, rsp_valid, pend_ff != 2'd0)
   `CBC_ASSERT_IMPL(a_at_most_two, clock, reset, req_acc, pend_ff != 2'd2)
   `CBC_ASSERT_IMPL(a_used_nonzero, clock, reset, rsp_valid, rsp_used_bins != '0)
endmodule

bind color_bin_compaction_unit cbc_checker u_cbc_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_ch.valid),
   .req_ready     (req_ch.ready),
   .rsp_valid     (rsp_ch.valid),
   .rsp_ready     (rsp_ch.ready),
   .rsp_bin_index (rsp_ch.bin_index),
   .rsp_used_bins (rsp_ch.used_bins)
);
